// ===== design/tcph_pkg.sv =====
// shared types, register codes and the ones' complement fold for the
// transport checksum block; no dependencies
package tcph_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ADDR_W    = 64;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IPV6_MODE   = 3'd0,
        CFG_SRC_UPPER   = 3'd1,
        CFG_SRC_LOWER   = 3'd2,
        CFG_DST_UPPER   = 3'd3,
        CFG_DST_LOWER   = 3'd4,
        CFG_PROTOCOL    = 3'd5
    } t_cfg_reg;

    localparam logic [7:0] PROTOCOL_RESET = 8'd6;

    // cycles the pseudo-header sum needs after a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // pseudo-header state handed to the summing stage
    typedef struct packed {
        logic        ipv6;
        logic [15:0] sum;
        logic        settled;
    } t_pseudo;

    // one accepted word of the byte stream
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_byte_word;

    // folds a 20-bit sum of 16-bit words back into 16 bits with end-around
    // carry; zero stays zero and any non-zero total stays non-zero
    function automatic logic [15:0] fold20(input logic [19:0] x);
        logic [16:0] t;
        t = 17'(x[15:0]) + 17'(x[19:16]);
        return t[15:0] + 16'(t[16]);
    endfunction

endpackage

// ===== design/transport_checksum_pseudo_header.sv =====
// top level of the tcp/udp checksum engine with ipv4/ipv6 pseudo-header
// depends on tcph_pkg, tcph_cfg and tcph_sum
//
// usage
//   input channel (i_valid / o_ready): one segment byte per word in network
//   order, i_last_byte high on the final byte; a segment holds at least one
//   byte. output channel (o_valid / i_ready): one checksum word per segment,
//   the complemented folded sum ready to drop into the header field.
//   configuration channel (i_cfg_valid / o_cfg_ready): register index and 64-bit
//   data; the user writes only while no segment result is outstanding (not enforced).
// pipeline and throughput
//   one byte per cycle sustained while o_ready is high. a last byte passes
//   two register stages (input register, result register) before o_valid
//   rises. the result register frees itself in the same cycle it is
//   taken, so segments stream back to back.
//   after reset and after every register write, o_ready stays low while
//   the registered pseudo-header sum is rebuilt.
// reset
//   synchronous, active low: segment state cleared, registers to defaults
//   (ipv4, addresses zero, protocol 6), both channels empty.
// stall
//   while a checksum waits on i_ready, non-last bytes keep flowing; a last
//   byte waits in the input register and o_ready drops behind it.
module transport_checksum_pseudo_header import tcph_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte stream
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // checksum result
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_checksum_value,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_pseudo     pseudo;
    t_byte_word  r_in;
    logic        r_in_valid;
    logic        r_out_valid;
    logic [15:0] r_out_checksum;
    logic [15:0] checksum;
    logic        out_free;
    logic        advance;
    logic        in_accept;
    logic        cfg_write;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    tcph_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (cfg_write),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_pseudo   (pseudo)
    );

    // the result register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_ready;
    // a non-last byte only updates the sum; a last byte needs a result slot
    assign advance  = r_in_valid && (!r_in.last || out_free);
    assign o_ready  = pseudo.settled && (!r_in_valid || advance);
    assign in_accept = i_valid && o_ready;

    tcph_sum #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_word     (r_in),
        .i_pseudo   (pseudo),
        .o_checksum (checksum)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.data <= i_data_byte;
            r_in.last <= i_last_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out_checksum <= checksum;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_checksum_value = r_out_checksum;

    // a new checksum only appears behind a last byte leaving the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.last))
        else $error("checksum appeared without a last byte");

    // a last byte never overruns a stalled result
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.last && r_out_valid && !i_ready)
        |=> (r_in_valid && r_in.last && r_out_valid))
        else $error("last byte overran a stalled checksum");

    // the pseudo-header sum is rebuilt before the next byte enters
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_write |=> !in_accept ##1 !in_accept)
        else $error("byte taken before pseudo-header sum settled");

endmodule

// ===== design/tcph_cfg.sv =====
// configuration registers and the registered pseudo-header address sum
// depends on tcph_pkg
module tcph_cfg import tcph_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [ADDR_W-1:0]    i_wr_data,
    output t_pseudo              o_pseudo
);

    logic              r_ipv6_mode;
    logic [ADDR_W-1:0] r_src_upper;
    logic [ADDR_W-1:0] r_src_lower;
    logic [ADDR_W-1:0] r_dst_upper;
    logic [ADDR_W-1:0] r_dst_lower;
    logic [7:0]        r_protocol;
    logic [1:0]        r_settle;

    logic [17:0] r_part [4];
    logic [17:0] n_part [4];
    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [15:0] addr_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipv6_mode <= 1'b0;
            r_src_upper <= '0;
            r_src_lower <= '0;
            r_dst_upper <= '0;
            r_dst_lower <= '0;
            r_protocol  <= PROTOCOL_RESET;
        end else if (i_wr_en) begin
            unique case (t_cfg_reg'(i_wr_index))
                CFG_IPV6_MODE: r_ipv6_mode <= i_wr_data[0];
                CFG_SRC_UPPER: r_src_upper <= i_wr_data;
                CFG_SRC_LOWER: r_src_lower <= i_wr_data;
                CFG_DST_UPPER: r_dst_upper <= i_wr_data;
                CFG_DST_LOWER: r_dst_lower <= i_wr_data;
                CFG_PROTOCOL:  r_protocol  <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // settle count: holds the input off until both sum stages reflect the
    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYCLES;
        end else if (i_wr_en) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // stage a: word sums of each address register, ipv4 keeps the low
    // two words of the lower registers only
    always_comb begin
        if (r_ipv6_mode) begin
            n_part[0] = 18'(r_src_upper[63:48]) + 18'(r_src_upper[47:32])
                      + 18'(r_src_upper[31:16]) + 18'(r_src_upper[15:0]);
            n_part[1] = 18'(r_src_lower[63:48]) + 18'(r_src_lower[47:32])
                      + 18'(r_src_lower[31:16]) + 18'(r_src_lower[15:0]);
            n_part[2] = 18'(r_dst_upper[63:48]) + 18'(r_dst_upper[47:32])
                      + 18'(r_dst_upper[31:16]) + 18'(r_dst_upper[15:0]);
            n_part[3] = 18'(r_dst_lower[63:48]) + 18'(r_dst_lower[47:32])
                      + 18'(r_dst_lower[31:16]) + 18'(r_dst_lower[15:0]);
        end else begin
            n_part[0] = '0;
            n_part[1] = 18'(r_src_lower[31:16]) + 18'(r_src_lower[15:0]);
            n_part[2] = '0;
            n_part[3] = 18'(r_dst_lower[31:16]) + 18'(r_dst_lower[15:0]);
        end
    end

    // stage b: the four parts fit 20 bits, fold them before the protocol
    // word joins
    assign addr_fold = fold20(20'(r_part[0]) + 20'(r_part[1]) + 20'(r_part[2])
                            + 20'(r_part[3]));
    assign n_sum     = fold20(20'(addr_fold) + 20'(r_protocol));

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_sum  <= n_sum;
    end

    assign o_pseudo.ipv6    = r_ipv6_mode;
    assign o_pseudo.sum     = r_sum;
    assign o_pseudo.settled = (r_settle == 2'd0);

endmodule

// ===== design/tcph_sum.sv =====
// running ones' complement sum, byte pairing, length count and the final
// checksum of a segment; depends on tcph_pkg
module tcph_sum import tcph_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_byte_word  i_word,
    input  t_pseudo     i_pseudo,
    output logic [15:0] o_checksum
);

    logic [15:0]            r_running_sum;
    logic [7:0]             r_pending_high;
    logic                   r_odd;
    logic [LENGTH_BITS-1:0] r_length;

    logic [15:0]            n_running_sum;
    logic [15:0]            pair_word;
    logic [16:0]            pair_add;
    logic [LENGTH_BITS-1:0] n_length;
    logic [31:0]            len32;
    logic [15:0]            len_hi;
    logic [15:0]            final_sum;

    // odd trailing byte pads as the high byte of its word
    assign pair_word = r_odd ? {r_pending_high, i_word.data} : {i_word.data, 8'h00};
    assign pair_add  = 17'(r_running_sum) + 17'(pair_word);
    assign n_running_sum = pair_add[15:0] + 16'(pair_add[16]);

    // saturating byte count, the current byte included
    assign n_length = (r_length == '1) ? r_length : r_length + LENGTH_BITS'(1);
    assign len32    = 32'(n_length);
    assign len_hi   = i_pseudo.ipv6 ? len32[31:16] : 16'h0000;

    assign final_sum = fold20(20'(r_running_sum) + 20'(pair_word) + 20'(i_pseudo.sum)
                            + 20'(len_hi) + 20'(len32[15:0]));
    assign o_checksum = ~final_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum  <= '0;
            r_pending_high <= '0;
            r_odd          <= 1'b0;
            r_length       <= '0;
        end else if (i_step) begin
            if (i_word.last) begin
                r_running_sum  <= '0;
                r_pending_high <= '0;
                r_odd          <= 1'b0;
                r_length       <= '0;
            end else begin
                r_length <= n_length;
                if (r_odd) begin
                    r_running_sum  <= n_running_sum;
                    r_pending_high <= '0;
                    r_odd          <= 1'b0;
                end else begin
                    r_pending_high <= i_word.data;
                    r_odd          <= 1'b1;
                end
            end
        end
    end

endmodule
